[rtl/vfcm_pkg.sv]
package vfcm_pkg;

	// section geometry
	localparam int SECTION_EDGE  = 16;
	localparam int SECTION_TOTAL = 16;

	// voxel queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic [1:0] REG_CULL_ENABLE = 2'd0;
	localparam logic [1:0] REG_CHUNK_COL_X = 2'd1;
	localparam logic [1:0] REG_CHUNK_COL_Z = 2'd2;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 21;

	localparam int NUM_FACES   = 6;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 112;

	typedef logic [2:0] ofs_t; // {dx, dy, dz}

	// corner offsets per face (top, bottom, north, south, west, east) and corner
	localparam ofs_t CORNER_OFS [0:NUM_FACES-1][0:3] = '{
		'{3'b011, 3'b111, 3'b110, 3'b010},
		'{3'b000, 3'b100, 3'b101, 3'b001},
		'{3'b010, 3'b110, 3'b100, 3'b000},
		'{3'b111, 3'b011, 3'b001, 3'b101},
		'{3'b011, 3'b010, 3'b000, 3'b001},
		'{3'b110, 3'b111, 3'b101, 3'b100}
	};

	// one classified voxel waiting for the emitter
	typedef struct packed {
		logic [25:0] base_x;
		logic [8:0]  base_y;
		logic [25:0] base_z;
		logic [7:0]  block_id;
		logic [5:0]  faces;
		logic        start;
	} vox_entry_t;

	// one vertex word
	typedef struct packed {
		logic [31:0] vertex_index;
		logic [7:0]  vertex_block_id;
		logic [1:0]  corner;
		logic [2:0]  face_dir;
		logic [25:0] vertex_z;
		logic [8:0]  vertex_y;
		logic [25:0] vertex_x;
		logic        last;
	} vertex_t;

endpackage

[rtl/vfcm_front.sv]
module vfcm_front
	import vfcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic [IN_TDATA_W-1:0] in_data,
	input  logic                  q_full,
	output logic                  in_ready,
	output logic                  push,
	output vox_entry_t            entry
);

	logic              cull_enable_q;
	logic signed [20:0] chunk_col_x_q;
	logic signed [20:0] chunk_col_z_q;

	logic [3:0] lx, ly, lz, sec;
	logic [7:0] bid;
	logic       is_air, start, in_range;
	logic [5:0] open, faces;
	logic signed [31:0] col_x_ext, col_z_ext;
	logic [31:0] wx, wy, wz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_enable_q <= 1'b1;
			chunk_col_x_q <= '0;
			chunk_col_z_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_CULL_ENABLE: cull_enable_q <= cfg_wdata[0];
				REG_CHUNK_COL_X: chunk_col_x_q <= cfg_wdata;
				REG_CHUNK_COL_Z: chunk_col_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign lx     = in_data[3:0];
	assign ly     = in_data[7:4];
	assign lz     = in_data[11:8];
	assign sec    = in_data[15:12];
	assign bid    = in_data[23:16];
	assign is_air = in_data[24];
	assign open   = in_data[30:25];
	assign start  = in_data[31];

	assign in_range = (32'(lx) < SECTION_EDGE) && (32'(ly) < SECTION_EDGE) &&
		(32'(lz) < SECTION_EDGE) && (32'(sec) < SECTION_TOTAL);

	always_comb begin
		if (is_air || !in_range)
			faces = '0;
		else if (cull_enable_q)
			faces = open;
		else
			faces = '1;
	end

	// world base corner, wrapped to the output widths
	assign col_x_ext = 32'(chunk_col_x_q);
	assign col_z_ext = 32'(chunk_col_z_q);
	assign wx = 32'(col_x_ext * SECTION_EDGE) + 32'(lx);
	assign wy = 32'(sec) * 32'(SECTION_EDGE) + 32'(ly);
	assign wz = 32'(col_z_ext * SECTION_EDGE) + 32'(lz);

	assign entry.base_x   = wx[25:0];
	assign entry.base_y   = wy[8:0];
	assign entry.base_z   = wz[25:0];
	assign entry.block_id = bid;
	assign entry.faces    = faces;
	assign entry.start    = start;

	// voxels that neither emit nor restart the count never enter the queue
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && ((faces != '0) || start);

endmodule

[rtl/vfcm_queue.sv]
module vfcm_queue
	import vfcm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  vox_entry_t        push_entry,
	input  logic              pop,
	output logic              not_empty,
	output logic              full,
	output logic [QCNT_W-1:0] count,
	output vox_entry_t        head
);

	vox_entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head      = slot_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign full      = (32'(count_q) == QDEPTH);
	assign count     = count_q;

endmodule

[rtl/vfcm_back.sv]
module vfcm_back
	import vfcm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  vox_entry_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output vertex_t    out_word
);

	logic        act_q;
	logic [5:0]  mask_q;
	logic [1:0]  corner_q;
	logic [25:0] bx_q, bz_q;
	logic [8:0]  by_q;
	logic [7:0]  bid_q;
	logic [31:0] count_q;
	logic        out_valid_q;
	vertex_t     out_q;

	logic [2:0]  face;
	logic [5:0]  mask_clr;
	ofs_t        ofs;
	logic        last_v, emit;

	always_comb begin
		face = '0;
		for (int i = NUM_FACES - 1; i >= 0; i--) begin
			if (mask_q[i])
				face = 3'(i);
		end
	end

	assign ofs      = CORNER_OFS[face][corner_q];
	assign mask_clr = mask_q & ~(6'b1 << face);
	assign last_v   = (corner_q == 2'd3) && (mask_clr == '0);
	assign emit     = act_q && (!out_valid_q || out_ready);
	assign pop      = q_not_empty && (!act_q || (emit && last_v));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			mask_q      <= '0;
			corner_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				act_q    <= (head.faces != '0);
				mask_q   <= head.faces;
				corner_q <= '0;
			end else if (emit) begin
				corner_q <= corner_q + 1'b1;
				if (corner_q == 2'd3)
					mask_q <= mask_clr;
				if (last_v)
					act_q <= 1'b0;
			end
			if (pop && head.start)
				count_q <= '0;
			else if (emit)
				count_q <= count_q + 1'b1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bx_q  <= head.base_x;
			by_q  <= head.base_y;
			bz_q  <= head.base_z;
			bid_q <= head.block_id;
		end
		if (emit) begin
			out_q.vertex_x        <= bx_q + 26'(ofs[2]);
			out_q.vertex_y        <= by_q + 9'(ofs[1]);
			out_q.vertex_z        <= bz_q + 26'(ofs[0]);
			out_q.face_dir        <= face;
			out_q.corner          <= corner_q;
			out_q.vertex_block_id <= bid_q;
			out_q.vertex_index    <= count_q;
			out_q.last            <= last_v;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

[rtl/voxel_face_cull_mesher_unit.sv]
// voxel face culling mesher
// input stream: one voxel word per handshake; the front classifies it (air,
// out of section, culling against neighbour_open) and forms its world base
// corner, then parks it in a four-entry queue if it has faces or mesh_start
// output stream: one vertex word per handshake, four per emitted face, faces
// in the order top, bottom, north, south, west, east; tlast marks the final
// vertex of a voxel
// path of a voxel: the queue slot, then the emitter's voxel registers, then
// the output register that offers its first vertex
// throughput: the emitter makes one vertex a cycle while the output register
// is free or being taken, four per emitted face; a voxel that emits nothing but
// carries mesh_start is still popped, any other empty voxel never enters the
// queue, and the input takes one word a cycle while the queue has room
// the emitter loads the next queued voxel in the cycle it sends the last
// vertex of the current one, so faces stream without gaps
// receiver stall: the output register holds its word; the emitter waits, the
// queue fills, then s_axis_tready drops
// reset: queue empty, vertex counter zero, culling on, chunk column at zero
// configuration is written through cfg_wr_en / cfg_addr / cfg_wdata while idle
module voxel_face_cull_mesher_unit
	import vfcm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	// voxel input
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// local_x[3:0] local_y[7:4] local_z[11:8] section_number[15:12]
	// block_id[23:16] is_air[24] neighbour_open[30:25] mesh_start[31]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// vertex output
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// vertex_x[25:0] vertex_y[34:26] vertex_z[60:35] face_dir[63:61]
	// corner[65:64] vertex_block_id[73:66] vertex_index[105:74] zero[111:106]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	vox_entry_t        push_entry, head;
	logic              push, pop, q_full, q_not_empty;
	logic [QCNT_W-1:0] q_count;
	vertex_t           vtx;

	// front: config registers, classification, world base
	vfcm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.q_full    (q_full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.entry     (push_entry)
	);

	// decoupling queue
	vfcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.full       (q_full),
		.count      (q_count),
		.head       (head)
	);

	// back: face walk, corner walk, vertex counter, output register
	vfcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_word    (vtx)
	);

	assign m_axis_tdata = {6'b0, vtx.vertex_index, vtx.vertex_block_id, vtx.corner,
		vtx.face_dir, vtx.vertex_z, vtx.vertex_y, vtx.vertex_x};
	assign m_axis_tlast = vtx.last;

	// a voxel always closes on the fourth corner of a face
	a_last_on_corner3: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[65:64] == 2'd3)
		else $error("tlast on a corner other than the fourth");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:61] <= 3'd5)
		else $error("face_dir out of range");

	// within a voxel, vertices follow each other without bubbles
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("gap inside a voxel's vertex run");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> 32'(q_count) < QDEPTH)
		else $error("queue push while full");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

// checks the voxel face mesher against a cycle-free predictor of the vertex stream
// directed table first, then random phases with a fresh register setting each
module tb_top;
	import vfcm_pkg::*;

	// face codes, the order in which faces are emitted
	typedef enum logic [2:0] {
		FACE_TOP    = 3'd0,
		FACE_BOTTOM = 3'd1,
		FACE_NORTH  = 3'd2,
		FACE_SOUTH  = 3'd3,
		FACE_WEST   = 3'd4,
		FACE_EAST   = 3'd5
	} face_t;

	// one expected vertex
	typedef struct {
		logic [25:0] vx;
		logic [8:0]  vy;
		logic [25:0] vz;
		logic [2:0]  face;
		logic [1:0]  corner;
		logic [7:0]  bid;
		logic [31:0] idx;
		logic        is_last;
	} vert_t;

	// one row of the directed stimulus: a register write or a voxel word
	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		logic [20:0] value;
		logic [31:0] word;
		bit          pinned; // first vertex typed in by hand
		logic [25:0] x0;
		logic [8:0]  y0;
		logic [25:0] z0;
		logic [31:0] idx0;
	} step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_valid;
	logic                   s_ready;
	logic [IN_TDATA_W-1:0]  s_data;
	logic                   m_valid;
	logic                   m_ready;
	logic [OUT_TDATA_W-1:0] m_data;
	logic                   m_last;

	// predictor copy of the block's registers and counter
	logic        cull_on;
	logic [20:0] chunk_x;
	logic [20:0] chunk_z;
	logic [31:0] vert_count;

	vert_t vert_q[$];
	step_t dir_steps[$];

	bit calm; // no gaps on either side
	int fails;
	int n_voxels, n_air, n_checked, n_writes;
	int rx_hold;

	voxel_face_cull_mesher_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tlast  (m_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog, far above the slowest legal run
	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// corner offsets {dx, dy, dz} of a face, corner 0 in the low bits
	function automatic logic [2:0] corner_ofs(input int f, input int c);
		logic [11:0] r;
		case (f)
			FACE_TOP:    r = {3'b010, 3'b110, 3'b111, 3'b011};
			FACE_BOTTOM: r = {3'b001, 3'b101, 3'b100, 3'b000};
			FACE_NORTH:  r = {3'b000, 3'b100, 3'b110, 3'b010};
			FACE_SOUTH:  r = {3'b101, 3'b001, 3'b011, 3'b111};
			FACE_WEST:   r = {3'b001, 3'b000, 3'b010, 3'b011};
			default:     r = {3'b100, 3'b101, 3'b111, 3'b110};
		endcase
		return r[c*3 +: 3];
	endfunction

	// pack a voxel word, local_x in the low bits
	function automatic logic [31:0] vox(input logic [3:0] lx, input logic [3:0] ly,
		input logic [3:0] lz, input logic [3:0] sec, input logic [7:0] bid,
		input logic air, input logic [5:0] open, input logic start);
		return {start, open, air, bid, sec, lz, ly, lx};
	endfunction

	function automatic step_t vrow(input logic [31:0] w);
		step_t s;
		s = '{default: '0};
		s.word = w;
		return s;
	endfunction

	function automatic step_t prow(input logic [31:0] w, input logic [25:0] x0,
		input logic [8:0] y0, input logic [25:0] z0, input logic [31:0] idx0);
		step_t s;
		s = vrow(w);
		s.pinned = 1'b1;
		s.x0 = x0;
		s.y0 = y0;
		s.z0 = z0;
		s.idx0 = idx0;
		return s;
	endfunction

	function automatic step_t crow(input logic [1:0] r, input logic [20:0] v);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.reg_idx = r;
		s.value = v;
		return s;
	endfunction

	// append one row to the directed table
	task automatic add_step(input step_t s);
		dir_steps.insert(dir_steps.size(), s);
	endtask

	// mostly short gaps, a few long ones
	function automatic int long_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		else if (r < 95) return $urandom_range(4, 10);
		else return $urandom_range(20, 60);
	endfunction

	function automatic int send_gap();
		if (calm) return 0;
		if ($urandom_range(0, 99) < 55) return 0;
		return long_gap();
	endfunction

	// chunk column with the extremes weighted in
	function automatic logic [20:0] pick_chunk();
		case ($urandom_range(0, 4))
			0: return 21'h0FFFFF;
			1: return 21'h100000;
			2: return 21'($signed($urandom_range(0, 8)) - 4);
			default: return 21'($urandom);
		endcase
	endfunction

	// expand one accepted voxel into its vertex list
	task automatic predict_voxel(input logic [31:0] w, output int n);
		logic [5:0]  faces;
		logic [25:0] bx, bz;
		logic [8:0]  by;
		logic [2:0]  ofs;
		vert_t       v;
		vert_t       vlist[24];
		n = 0;
		n_voxels++;
		if (w[31])
			vert_count = '0; // mesh_start clears even when nothing is emitted
		if (w[24]) begin
			n_air++;
		end else begin
			faces = cull_on ? w[30:25] : 6'h3F;
			bx = ({{5{chunk_x[20]}}, chunk_x} << 4) | 26'(w[3:0]);
			by = {1'b0, w[15:12], w[7:4]};
			bz = ({{5{chunk_z[20]}}, chunk_z} << 4) | 26'(w[11:8]);
			for (int f = 0; f < NUM_FACES; f++) begin
				if (faces[f]) begin
					for (int c = 0; c < 4; c++) begin
						ofs = corner_ofs(f, c);
						v.vx = bx + 26'(ofs[2]);
						v.vy = by + 9'(ofs[1]);
						v.vz = bz + 26'(ofs[0]);
						v.face = 3'(f);
						v.corner = 2'(c);
						v.bid = w[23:16];
						v.idx = vert_count;
						v.is_last = 1'b0;
						vert_count = vert_count + 32'd1;
						vlist[n] = v;
						n++;
					end
				end
			end
			if (n > 0)
				vlist[n-1].is_last = 1'b1;
			for (int i = 0; i < n; i++)
				vert_q.insert(vert_q.size(), vlist[i]);
		end
	endtask

	// present one voxel word, return at the edge that takes it
	task automatic send_word(input logic [31:0] w, input int gap);
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= w;
		do @(negedge clk); while (!s_ready);
		@(posedge clk);
	endtask

	// hold the input until every vertex is out and the queue has emptied
	task automatic wait_idle();
		s_valid <= 1'b0;
		while (vert_q.size() != 0) @(posedge clk);
		// empty voxels with mesh_start may still sit in the queue
		repeat (12) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] r, input logic [20:0] v);
		cfg_wr_en <= 1'b1;
		cfg_addr <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_writes++;
		case (r)
			REG_CULL_ENABLE: cull_on = v[0]; // upper bits have no effect
			REG_CHUNK_COL_X: chunk_x = v;
			REG_CHUNK_COL_Z: chunk_z = v;
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0h actual %0h", name, want, got);
			fails++;
		end
	endtask

	// receiver: random stalls, none while calm
	initial begin
		m_ready <= 1'b0;
		rx_hold = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0 && !calm) begin
				m_ready <= 1'b0;
				rx_hold--;
			end else begin
				m_ready <= 1'b1;
				rx_hold = 0;
				if (!calm && $urandom_range(0, 99) < 25)
					rx_hold = long_gap();
			end
		end
	end

	// vertex check: a word with valid and ready at the falling edge is taken at the next rise
	always @(negedge clk) begin : vertex_check
		vert_t e;
		if (arst_n && m_valid && m_ready) begin
			if (vert_q.size() == 0) begin
				$error("vertex word with nothing expected: %0h", m_data);
				fails++;
			end else begin
				e = vert_q.pop_front();
				n_checked++;
				check_field("vertex_x", 32'(e.vx), 32'(m_data[25:0]));
				check_field("vertex_y", 32'(e.vy), 32'(m_data[34:26]));
				check_field("vertex_z", 32'(e.vz), 32'(m_data[60:35]));
				check_field("face_dir", 32'(e.face), 32'(m_data[63:61]));
				check_field("corner", 32'(e.corner), 32'(m_data[65:64]));
				check_field("vertex_block_id", 32'(e.bid), 32'(m_data[73:66]));
				check_field("vertex_index", e.idx, m_data[105:74]);
				check_field("last", 32'(e.is_last), 32'(m_last));
			end
		end
	end

	// stimulus
	initial begin : stim
		step_t s;
		vert_t e;
		logic [31:0] w;
		logic [5:0] open;
		int n, k, guard;
		fails = 0;
		n_voxels = 0;
		n_air = 0;
		n_checked = 0;
		n_writes = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr <= '0;
		cfg_wdata <= '0;
		s_valid <= 1'b0;
		s_data <= '0;
		// reset values of the block
		cull_on = 1'b1;
		chunk_x = '0;
		chunk_z = '0;
		vert_count = '0;

		// directed rows; pinned rows carry a hand-worked first vertex
		// right after reset: culling on, chunk at the origin
		add_step(prow(vox(0, 0, 0, 0, 8'h00, 0, 6'b1 << FACE_TOP, 1),
			26'd0, 9'd1, 26'd1, 32'd0));
		// top corner of the chunk, every face open
		add_step(prow(vox(15, 15, 15, 15, 8'hFF, 0, 6'h3F, 0),
			26'd15, 9'd256, 26'd16, 32'd4));
		// air emits nothing
		add_step(vrow(vox(5, 5, 5, 5, 8'h12, 1, 6'h3F, 0)));
		// fully enclosed voxel is culled away
		add_step(vrow(vox(7, 8, 9, 3, 8'h34, 0, 6'h00, 0)));
		// mesh_start on an air voxel still clears the counter
		add_step(vrow(vox(2, 2, 2, 2, 8'h56, 1, 6'h00, 1)));
		add_step(prow(vox(1, 2, 3, 4, 8'hA5, 0, 6'b1 << FACE_BOTTOM, 0),
			26'd1, 9'd66, 26'd3, 32'd0));
		add_step(vrow(vox(3, 4, 5, 6, 8'h5A, 0, 6'b1 << FACE_NORTH, 0)));
		add_step(vrow(vox(6, 5, 4, 3, 8'h0F, 0, 6'b1 << FACE_SOUTH, 0)));
		add_step(vrow(vox(9, 10, 11, 12, 8'hF0, 0, 6'b1 << FACE_WEST, 0)));
		add_step(vrow(vox(12, 11, 10, 9, 8'h81, 0, 6'b1 << FACE_EAST, 0)));
		add_step(vrow(vox(8, 0, 15, 1, 8'h7E, 0,
			(6'b1 << FACE_NORTH) | (6'b1 << FACE_EAST), 0)));
		// culling off: neighbour bits are ignored
		add_step(crow(REG_CULL_ENABLE, 21'd0));
		add_step(vrow(vox(4, 4, 4, 4, 8'hC3, 0, 6'h00, 0)));
		add_step(vrow(vox(4, 4, 4, 4, 8'hC3, 1, 6'h15, 1)));
		// chunk column at the extremes
		add_step(crow(REG_CHUNK_COL_X, 21'h0FFFFF));
		add_step(crow(REG_CHUNK_COL_Z, 21'h100000));
		add_step(prow(vox(15, 0, 0, 0, 8'h99, 0, 6'h00, 1),
			26'h0FFFFFF, 9'd1, 26'h3000001, 32'd0));
		add_step(vrow(vox(0, 15, 15, 15, 8'h66, 0, 6'h2A, 0)));
		// chunk extremes swapped, then culling back on with junk above bit 0
		add_step(crow(REG_CHUNK_COL_X, 21'h100000));
		add_step(crow(REG_CHUNK_COL_Z, 21'h0FFFFF));
		add_step(crow(REG_CULL_ENABLE, 21'h1FFFFF));
		add_step(vrow(vox(0, 0, 15, 0, 8'h01, 0, 6'h3F, 0)));
		add_step(vrow(vox(15, 15, 0, 15, 8'h00, 0, 6'h33, 0)));
		// chunk at -1 / +1, culling off via a word whose bit 0 is clear
		add_step(crow(REG_CHUNK_COL_X, 21'h1FFFFF));
		add_step(crow(REG_CHUNK_COL_Z, 21'd1));
		add_step(crow(REG_CULL_ENABLE, 21'h1FFFFE));
		add_step(vrow(vox(0, 7, 0, 8, 8'hAA, 0, 6'h00, 0)));
		add_step(vrow(vox(15, 8, 15, 7, 8'h55, 0, 6'h0C, 0)));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_steps[i]) begin
			s = dir_steps[i];
			if (s.is_cfg) begin
				wait_idle();
				cfg_write(s.reg_idx, s.value);
			end else begin
				send_word(s.word, send_gap());
				predict_voxel(s.word, n);
				if (s.pinned && n > 0) begin
					// typed-in corner 0 of the first face replaces the predicted one
					e = vert_q[vert_q.size() - n];
					e.vx = s.x0;
					e.vy = s.y0;
					e.vz = s.z0;
					e.idx = s.idx0;
					vert_q[vert_q.size() - n] = e;
				end
			end
		end

		// random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			calm = (ph == 2);
			cfg_write(REG_CULL_ENABLE, (ph == 0) ? 21'h1FFFFF : 21'($urandom));
			cfg_write(REG_CHUNK_COL_X, pick_chunk());
			cfg_write(REG_CHUNK_COL_Z, pick_chunk());
			for (k = 0; k < 60; k++) begin
				// sender holds off until the output has drained
				if (ph == 4 && k == 30)
					wait_idle();
				case ($urandom_range(0, 9))
					0: open = 6'h3F;
					1: open = 6'h00;
					default: open = 6'($urandom);
				endcase
				w = vox(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
					8'($urandom), ($urandom_range(0, 99) < 15), open,
					($urandom_range(0, 99) < 6));
				send_word(w, send_gap());
				predict_voxel(w, n);
			end
		end
		calm = 1'b0;

		// drain, bounded so leftovers are reported rather than hung on
		s_valid <= 1'b0;
		guard = 0;
		while (vert_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (12) @(posedge clk);
		if (vert_q.size() != 0) begin
			$error("%0d expected vertices never arrived", vert_q.size());
			fails++;
		end

		$display("covered %0d voxels (%0d air), %0d vertices checked, %0d register writes",
			n_voxels, n_air, n_checked, n_writes);
		$display("culling on and off, chunk column at both extremes, random stalls on both sides");
		if (fails == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
rtl/vfcm_pkg.sv
rtl/vfcm_front.sv
rtl/vfcm_queue.sv
rtl/vfcm_back.sv
rtl/voxel_face_cull_mesher_unit.sv
tb/sv/tb_top.sv
